// ----- rtl/segment_sphere_crossing_macros.svh -----
// Assertion helpers shared by the RTL of the segment/sphere crossing test.
`ifndef SEGMENT_SPHERE_CROSSING_MACROS_SVH
`define SEGMENT_SPHERE_CROSSING_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define SSC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define SSC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ssc_pkg.sv -----
package ssc_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X = 2'd0,
    REG_CENTRE_Y = 2'd1,
    REG_CENTRE_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_e;

  // Decision bits that travel with an item behind the quadratic sums.
  typedef struct packed {
    logic empty;
    logic pre_hit;
    logic need_d;
  } ssc_flags_t;

endpackage

// ----- rtl/ssc_if.sv -----
interface ssc_seg_if #(parameter int unsigned COORD_BITS = 20);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] stop_x;
  logic signed [COORD_BITS-1:0] stop_y;
  logic signed [COORD_BITS-1:0] stop_z;
  modport source(output valid, start_x, start_y, start_z, stop_x, stop_y, stop_z,
                 input ready);
  modport sink(input valid, start_x, start_y, start_z, stop_x, stop_y, stop_z,
               output ready);
endinterface

interface ssc_res_if;
  logic valid;
  logic ready;
  logic crosses;
  logic empty_segment;
  modport source(output valid, crosses, empty_segment, input ready);
  modport sink(input valid, crosses, empty_segment, output ready);
endinterface

interface ssc_cfg_if #(parameter int unsigned COORD_BITS = 20);
  import ssc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [COORD_BITS-1:0] data;
  modport source(output valid, idx, data, input ready);
  modport sink(input valid, idx, data, output ready);
endinterface

// ----- rtl/segment_sphere_crossing.sv -----
// Segment/sphere crossing test, fully pipelined: one segment request can be
// accepted every clock cycle while the output is not stalled. The pipeline is
// the chain of three dot-product stages (differences, products, sums), one
// decision stage, two stages of the split wide multiplier that forms h*h and
// a*c for the discriminant, and the result register. A stall on the result
// side freezes the whole pipeline, so no request is lost or repeated; input
// ready follows output readiness in the same cycle. Sphere centre and radius
// are written through the configuration channel, which is always ready; write
// them only while no request is in flight. A zero-length segment reports
// empty_segment and never crosses.
module segment_sphere_crossing #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssc_cfg_if.sink           cfg_i,
  ssc_seg_if.sink           seg_i,
  ssc_res_if.source         res_o
);
  import ssc_pkg::*;

  localparam int unsigned N  = COORD_BITS;
  localparam int unsigned SW = 2 * N + 3;
  localparam int unsigned FW = 2 * N + 5;
  localparam int unsigned HW = N + 1;
  localparam int unsigned MW = 2 * HW;

  // Configuration registers.
  logic signed [N-1:0] cx_q, cy_q, cz_q;
  logic        [N-2:0] r_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      r_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.idx))
        REG_CENTRE_X: cx_q <= cfg_i.data;
        REG_CENTRE_Y: cy_q <= cfg_i.data;
        REG_CENTRE_Z: cz_q <= cfg_i.data;
        REG_RADIUS:   r_q  <= cfg_i.data[N-2:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the result register is free or drains.
  logic out_valid_q, en;
  assign en          = !out_valid_q || res_o.ready;
  assign seg_i.ready = en;

  // Stages 1 to 3: a = v.v, h = m.v, c = m.m - r*r.
  logic                 v3, e3;
  logic signed [SW-1:0] a3, h3, c3;

  ssc_dot #(.N(N)) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (seg_i.valid),
    .sx_i    (seg_i.start_x),
    .sy_i    (seg_i.start_y),
    .sz_i    (seg_i.start_z),
    .ex_i    (seg_i.stop_x),
    .ey_i    (seg_i.stop_y),
    .ez_i    (seg_i.stop_z),
    .cx_i    (cx_q),
    .cy_i    (cy_q),
    .cz_i    (cz_q),
    .r_i     (r_q),
    .valid_o (v3),
    .empty_o (e3),
    .a_o     (a3),
    .h_o     (h3),
    .c_o     (c3)
  );

  // Stage 4: signs of f(0) = c and f(1) = a + 2h + c, and the tests on where
  // the other root or the vertex lies. Only the case with both end points
  // outside the sphere and the vertex inside the segment needs the
  // discriminant, which the later stages settle.
  logic signed [FW-1:0] f1, t_a2h, t_ac, t_ah;
  logic c_neg, c_zero, c_pos, f_neg, f_zero, f_pos, h_neg;
  ssc_flags_t flags_d;

  assign f1    = FW'(a3) + (FW'(h3) <<< 1) + FW'(c3);
  assign t_a2h = FW'(a3) + (FW'(h3) <<< 1);
  assign t_ac  = FW'(a3) - FW'(c3);
  assign t_ah  = FW'(a3) + FW'(h3);

  assign c_neg  = c3[SW-1];
  assign c_zero = (c3 == '0);
  assign c_pos  = !c_neg && !c_zero;
  assign f_neg  = f1[FW-1];
  assign f_zero = (f1 == '0);
  assign f_pos  = !f_neg && !f_zero;
  assign h_neg  = h3[SW-1];

  always_comb begin
    flags_d.empty   = e3;
    flags_d.pre_hit = !e3 && ((c_neg && f_pos) || (c_pos && f_neg) ||
                      (c_zero && h_neg && !t_a2h[FW-1] && (t_a2h != '0)) ||
                      (!c_zero && f_zero && c_pos && !t_ac[FW-1] && (t_ac != '0)));
    flags_d.need_d  = !e3 && c_pos && f_pos && h_neg &&
                      !t_ah[FW-1] && (t_ah != '0);
  end

  logic            v4_q, v5_q, v6_q;
  ssc_flags_t      f4_q, f5_q, f6_q;
  logic [MW-1:0]   hm_q, am_q, cm_q;
  logic [2*MW-1:0] hh6, ac6;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f4_q <= flags_d;
      hm_q <= MW'(-h3);
      am_q <= MW'(a3);
      cm_q <= MW'(c3);
      f5_q <= f4_q;
      f6_q <= f5_q;
    end
  end

  // Stages 5 and 6: h*h and a*c as exact magnitudes.
  ssc_wmul #(.HW(HW)) u_mul_hh (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (hm_q),
    .y_i   (hm_q),
    .p_o   (hh6)
  );

  ssc_wmul #(.HW(HW)) u_mul_ac (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (am_q),
    .y_i   (cm_q),
    .p_o   (ac6)
  );

  // Stage 7: discriminant compare into the result register.
  logic crosses_q, empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v4_q        <= v3;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      out_valid_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      crosses_q <= f6_q.pre_hit || (f6_q.need_d && (hh6 >= ac6));
      empty_q   <= f6_q.empty;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.crosses       = crosses_q;
  assign res_o.empty_segment = empty_q;

`include "segment_sphere_crossing_macros.svh"

  `SSC_ASSERT_IMPLIES(a_empty_no_cross, out_valid_q && empty_q, !crosses_q, "empty segment crossed")
  `SSC_ASSERT_IMPLIES(a_stall_blocks_input, out_valid_q && !res_o.ready, !seg_i.ready, "input taken during stall")
  `SSC_ASSERT_ALWAYS(a_flags_exclusive, !(v6_q && f6_q.pre_hit && f6_q.need_d), "decision flags overlap")

endmodule

// ----- rtl/ssc_dot.sv -----
module ssc_dot #(
  parameter int unsigned N = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [N-1:0]   sx_i,
  input  logic signed [N-1:0]   sy_i,
  input  logic signed [N-1:0]   sz_i,
  input  logic signed [N-1:0]   ex_i,
  input  logic signed [N-1:0]   ey_i,
  input  logic signed [N-1:0]   ez_i,
  input  logic signed [N-1:0]   cx_i,
  input  logic signed [N-1:0]   cy_i,
  input  logic signed [N-1:0]   cz_i,
  input  logic        [N-2:0]   r_i,
  output logic                  valid_o,
  output logic                  empty_o,
  output logic signed [2*N+2:0] a_o,
  output logic signed [2*N+2:0] h_o,
  output logic signed [2*N+2:0] c_o
);
  localparam int unsigned DW = N + 1;
  localparam int unsigned PW = 2 * N + 2;
  localparam int unsigned SW = 2 * N + 3;
  localparam int unsigned RW = 2 * N - 2;

  // Stage 1: differences.
  logic signed [DW-1:0] vx_d, vy_d, vz_d, mx_d, my_d, mz_d;
  logic signed [DW-1:0] vx_q, vy_q, vz_q, mx_q, my_q, mz_q;
  logic [N-2:0] r1_q;
  logic v1_q, e1_q;

  assign vx_d = DW'(ex_i) - DW'(sx_i);
  assign vy_d = DW'(ey_i) - DW'(sy_i);
  assign vz_d = DW'(ez_i) - DW'(sz_i);
  assign mx_d = DW'(sx_i) - DW'(cx_i);
  assign my_d = DW'(sy_i) - DW'(cy_i);
  assign mz_d = DW'(sz_i) - DW'(cz_i);

  // Stage 2: products.
  logic signed [PW-1:0] vvx_d, vvy_d, vvz_d, mvx_d, mvy_d, mvz_d, mmx_d, mmy_d, mmz_d;
  logic signed [PW-1:0] vvx_q, vvy_q, vvz_q, mvx_q, mvy_q, mvz_q, mmx_q, mmy_q, mmz_q;
  logic [RW-1:0] rr_d, rr_q;
  logic v2_q, e2_q;

  assign vvx_d = PW'(vx_q) * PW'(vx_q);
  assign vvy_d = PW'(vy_q) * PW'(vy_q);
  assign vvz_d = PW'(vz_q) * PW'(vz_q);
  assign mvx_d = PW'(mx_q) * PW'(vx_q);
  assign mvy_d = PW'(my_q) * PW'(vy_q);
  assign mvz_d = PW'(mz_q) * PW'(vz_q);
  assign mmx_d = PW'(mx_q) * PW'(mx_q);
  assign mmy_d = PW'(my_q) * PW'(my_q);
  assign mmz_d = PW'(mz_q) * PW'(mz_q);
  assign rr_d  = RW'(r1_q) * RW'(r1_q);

  // Stage 3: sums.
  logic signed [SW-1:0] a_d, h_d, c_d, a_q, h_q, c_q;
  logic v3_q, e3_q;

  assign a_d = SW'(vvx_q) + SW'(vvy_q) + SW'(vvz_q);
  assign h_d = SW'(mvx_q) + SW'(mvy_q) + SW'(mvz_q);
  assign c_d = SW'(mmx_q) + SW'(mmy_q) + SW'(mmz_q) - $signed({5'b0, rr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx_q <= vx_d; vy_q <= vy_d; vz_q <= vz_d;
      mx_q <= mx_d; my_q <= my_d; mz_q <= mz_d;
      r1_q <= r_i;
      e1_q <= (vx_d == '0) && (vy_d == '0) && (vz_d == '0);
      vvx_q <= vvx_d; vvy_q <= vvy_d; vvz_q <= vvz_d;
      mvx_q <= mvx_d; mvy_q <= mvy_d; mvz_q <= mvz_d;
      mmx_q <= mmx_d; mmy_q <= mmy_d; mmz_q <= mmz_d;
      rr_q  <= rr_d;
      e2_q  <= e1_q;
      a_q <= a_d; h_q <= h_d; c_q <= c_d;
      e3_q <= e2_q;
    end
  end

  assign valid_o = v3_q;
  assign empty_o = e3_q;
  assign a_o     = a_q;
  assign h_o     = h_q;
  assign c_o     = c_q;
endmodule

// ----- rtl/ssc_wmul.sv -----
module ssc_wmul #(
  parameter int unsigned HW = 21
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*HW-1:0] x_i,
  input  logic [2*HW-1:0] y_i,
  output logic [4*HW-1:0] p_o
);
  // Two stages: four half-width partial products, then one assembling add.
  logic [2*HW-1:0] hh_q, hl_q, lh_q, ll_q;
  logic [2*HW:0]   mid;
  logic [4*HW-1:0] p_q;

  assign mid = {1'b0, hl_q} + {1'b0, lh_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= x_i[2*HW-1:HW] * y_i[2*HW-1:HW];
      hl_q <= x_i[2*HW-1:HW] * y_i[HW-1:0];
      lh_q <= x_i[HW-1:0] * y_i[2*HW-1:HW];
      ll_q <= x_i[HW-1:0] * y_i[HW-1:0];
      p_q  <= {hh_q, ll_q} + ((4*HW)'(mid) << HW);
    end
  end

  assign p_o = p_q;
endmodule
